>>> rtl/core/trf_pkg.sv
// Shared types and codes for the two-way ranging filter.
// Holds request structs, status codes, register indexes and stage records.
// No dependencies.
package trf_pkg;

	// Opcodes of an input request
	localparam logic OP_RANGE    = 1'b0;
	localparam logic OP_SLOT_END = 1'b1;

	// Configuration register indexes
	localparam logic [2:0] REG_CM_PER_TICK   = 3'd0;
	localparam logic [2:0] REG_MAX_FLIGHT    = 3'd1;
	localparam logic [2:0] REG_MIN_DISTANCE  = 3'd2;
	localparam logic [2:0] REG_MAX_DISTANCE  = 3'd3;
	localparam logic [2:0] REG_OUTLIER       = 3'd4;
	localparam logic [2:0] REG_SMOOTH_SHIFT  = 3'd5;
	localparam logic [2:0] REG_FRESH_MIN     = 3'd6;

	localparam int CFG_DATA_W = 24;

	// Register reset values
	localparam logic [15:0] RST_CM_PER_TICK  = 16'd30748;
	localparam logic [19:0] RST_MAX_FLIGHT   = 20'd40000;
	localparam logic [23:0] RST_MIN_DISTANCE = 24'd0;
	localparam logic [23:0] RST_MAX_DISTANCE = 24'd512000;
	localparam logic [23:0] RST_OUTLIER      = 24'd38400;
	localparam logic [2:0]  RST_SMOOTH_SHIFT = 3'd1;
	localparam logic [7:0]  RST_FRESH_MIN    = 8'd2;

	localparam logic [23:0] RAW_MAX   = 24'hFFFFFF;
	localparam logic [15:0] MM_MAX    = 16'hFFFF;
	localparam logic [7:0]  COUNT_MAX = 8'hFF;

	typedef enum logic [2:0] {
		ST_AVERAGED  = 3'd0,
		ST_SEEDED    = 3'd1,
		ST_LIMITS    = 3'd2,
		ST_OUTLIER   = 3'd3,
		ST_BAD_FLIGHT = 3'd4,
		ST_BAD_INDEX = 3'd5,
		ST_MASK      = 3'd6
	} status_t;

	typedef struct packed {
		logic        opcode;
		logic [3:0]  anchor_index;
		logic [39:0] poll_tx_time;
		logic [39:0] resp_rx_time;
		logic [31:0] reply_delay;
	} in_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  anchor_out;
		logic [23:0] raw_distance_q8;
		logic [15:0] estimate_mm;
		logic [7:0]  count_out;
		logic [15:0] slot_mask;
	} out_t;

	// Filter settings used by the anchor bank
	typedef struct packed {
		logic [23:0] min_distance_q8;
		logic [23:0] max_distance_q8;
		logic [23:0] outlier_threshold_q8;
		logic [2:0]  smoothing_shift;
		logic [7:0]  fresh_min_count;
	} filt_cfg_t;

	// Record after the flight stage
	typedef struct packed {
		logic        opcode;
		logic [3:0]  anchor;
		logic        flight_ok;
		logic [19:0] tof;
	} flight_rec_t;

	// Record after the scale stage
	typedef struct packed {
		logic        opcode;
		logic [3:0]  anchor;
		logic        flight_ok;
		logic [23:0] raw;
	} sample_rec_t;

endpackage

>>> rtl/core/trf_flight.sv
// Time-of-flight computation and range check for one ranging request.
// Depends on trf_pkg.
module trf_flight (
	input  logic [39:0] poll_tx_time,
	input  logic [39:0] resp_rx_time,
	input  logic [31:0] reply_delay,
	input  logic [19:0] max_flight_ticks,
	output logic [19:0] tof,
	output logic        flight_ok
);
	import trf_pkg::*;

	logic [41:0] diff;
	logic [40:0] half;
	logic        neg;
	logic        minus_one;
	logic        over;

	// Round trip minus reply, signed 42 bits
	assign diff = {2'b00, resp_rx_time} - {2'b00, poll_tx_time} - {10'd0, reply_delay};
	assign neg = diff[41];
	// Halving truncates toward zero, so minus one still gives zero flight
	assign minus_one = &diff;
	assign half = diff[41:1];
	assign over = half > {21'd0, max_flight_ticks};

	assign flight_ok = minus_one || (!neg && !over);
	assign tof = neg ? 20'd0 : half[19:0];

endmodule

>>> rtl/core/trf_scale.sv
// Scale flight ticks to centimeters q8 with saturation to 24 bits.
// Depends on trf_pkg.
module trf_scale (
	input  logic [19:0] tof,
	input  logic [15:0] cm_per_tick_q16,
	output logic [23:0] raw
);
	import trf_pkg::*;

	logic [35:0] prod;

	// Multiply by q16 scale, drop 8 fraction bits, saturate
	assign prod = {16'd0, tof} * {20'd0, cm_per_tick_q16};
	assign raw = (|prod[35:32]) ? RAW_MAX : prod[31:8];

endmodule

>>> rtl/core/trf_anchor_bank.sv
// Per-anchor estimate, seed flag, sample count and fresh bit, with the update
// that turns one scaled sample into a result. Depends on trf_pkg.
module trf_anchor_bank #(
	parameter int ANCHOR_COUNT = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  trf_pkg::filt_cfg_t     cfg,
	input  trf_pkg::sample_rec_t   sample,
	input  logic                   update,
	output trf_pkg::out_t          result
);
	import trf_pkg::*;

	localparam int AW = (ANCHOR_COUNT > 1) ? $clog2(ANCHOR_COUNT) : 1;

	logic [23:0] est_q   [ANCHOR_COUNT];
	logic        seeded_q[ANCHOR_COUNT];
	logic [7:0]  count_q [ANCHOR_COUNT];
	logic        fresh_q [ANCHOR_COUNT];

	logic [AW-1:0] idx;
	logic          good_index;
	logic          write_anchor;
	logic [23:0]   est_cur;
	logic          seeded_cur;
	logic [7:0]    count_cur;
	logic [23:0]   est_next;
	logic          seeded_next;
	logic [7:0]    count_next;
	logic [23:0]   diff;
	logic [31:0]   ema_sum;
	logic [31:0]   ema_shifted;
	logic [27:0]   est_x10;
	logic [19:0]   mm_wide;
	logic [15:0]   est_mm;
	logic [15:0]   mask;

	assign idx = sample.anchor[AW-1:0];
	assign good_index = {1'b0, sample.anchor} < 5'(ANCHOR_COUNT);
	assign est_cur = est_q[idx];
	assign seeded_cur = seeded_q[idx];
	assign count_cur = count_q[idx];

	// Collect fresh and counted anchors for the slot-end report
	always_comb begin
		mask = '0;
		for (int i = 0; i < ANCHOR_COUNT; i++) begin
			mask[i] = fresh_q[i] && (count_q[i] >= cfg.fresh_min_count);
		end
	end

	// EMA: (raw + (2^s - 1) * est) >> s, multiply done as shift minus one
	assign ema_sum = {8'd0, sample.raw} + ({8'd0, est_cur} << cfg.smoothing_shift)
		- {8'd0, est_cur};
	assign ema_shifted = ema_sum >> cfg.smoothing_shift;
	assign diff = (sample.raw >= est_cur) ? (sample.raw - est_cur) : (est_cur - sample.raw);

	// Classify the sample and form the result
	always_comb begin
		result = '0;
		result.status = ST_MASK;
		est_next = est_cur;
		seeded_next = seeded_cur;
		count_next = count_cur;
		write_anchor = 1'b0;
		if (sample.opcode == OP_SLOT_END) begin
			result.status = ST_MASK;
			result.slot_mask = mask;
		end else begin
			result.anchor_out = sample.anchor;
			if (!good_index) begin
				result.status = ST_BAD_INDEX;
			end else if (!sample.flight_ok) begin
				result.status = ST_BAD_FLIGHT;
			end else begin
				write_anchor = 1'b1;
				result.raw_distance_q8 = sample.raw;
				if (sample.raw < cfg.min_distance_q8 || sample.raw > cfg.max_distance_q8) begin
					result.status = ST_LIMITS;
				end else if (!seeded_cur) begin
					result.status = ST_SEEDED;
					est_next = sample.raw;
					seeded_next = 1'b1;
					count_next = 8'd1;
				end else if (diff > cfg.outlier_threshold_q8) begin
					result.status = ST_OUTLIER;
				end else begin
					result.status = ST_AVERAGED;
					est_next = ema_shifted[23:0];
					count_next = (count_cur == COUNT_MAX) ? COUNT_MAX : count_cur + 8'd1;
				end
			end
			if (good_index) begin
				result.estimate_mm = est_mm;
				result.count_out = count_next;
			end
		end
	end

	// Millimeters: est * 10 / 256, clamped, zero while unseeded
	assign est_x10 = ({4'd0, est_next} << 3) + ({4'd0, est_next} << 1);
	assign mm_wide = est_x10[27:8];
	always_comb begin
		if (!seeded_next) begin
			est_mm = '0;
		end else if (|mm_wide[19:16]) begin
			est_mm = MM_MAX;
		end else begin
			est_mm = mm_wide[15:0];
		end
	end

	// Commit anchor state as the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ANCHOR_COUNT; i++) begin
				est_q[i] <= '0;
				seeded_q[i] <= 1'b0;
				count_q[i] <= '0;
				fresh_q[i] <= 1'b0;
			end
		end else if (update) begin
			if (sample.opcode == OP_SLOT_END) begin
				for (int i = 0; i < ANCHOR_COUNT; i++) begin
					fresh_q[i] <= 1'b0;
				end
			end else if (write_anchor) begin
				fresh_q[idx] <= 1'b1;
				est_q[idx] <= est_next;
				seeded_q[idx] <= seeded_next;
				count_q[idx] <= count_next;
			end
		end
	end

endmodule

>>> rtl/core/twr_range_filter_top.sv
// Top level of the two-way ranging filter: configuration registers,
// pipeline registers and handshake. Depends on trf_pkg and the trf modules.
//
// Use:
//   in_valid/in_ready/in_item carry requests: opcode 0 is a range sample for
//   one anchor, opcode 1 ends a slot and reports the fresh mask. Each request
//   gives exactly one result on out_valid/out_ready/out_item, in order.
//   cfg_we/cfg_index/cfg_data write the filter registers; write them only
//   while no request is in flight.
// Timing:
//   A request passes the input register, the flight stage (subtract and range
//   check), the scale stage (20x16 multiply) and the result register, where
//   anchor state updates.
//   One request per cycle is accepted while the output keeps being taken.
// Stall:
//   Each stage advances when the one after it is empty or moving, so
//   requests keep entering until all stages hold items; a result waits in
//   the result register, unchanged, until taken.
// Reset:
//   arst_n clears all stages, every anchor's estimate, seed flag, count and
//   fresh bit, and loads the register defaults.
module twr_range_filter_top #(
	parameter int ANCHOR_COUNT = 6
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  trf_pkg::in_t                       in_item,
	output logic                               out_valid,
	input  logic                               out_ready,
	output trf_pkg::out_t                      out_item,
	input  logic                               cfg_we,
	input  logic [2:0]                         cfg_index,
	input  logic [trf_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import trf_pkg::*;

	logic [15:0]  cm_per_tick_q;
	logic [19:0]  max_flight_q;
	filt_cfg_t    filt_cfg_q;

	logic         v_s1, v_s2, v_s3;
	in_t          item_s1;
	flight_rec_t  flight_s2;
	sample_rec_t  sample_s3;

	logic         en_out, en3, en2, en1;
	logic [19:0]  tof;
	logic         flight_ok;
	logic [23:0]  raw;
	out_t         result;

	// Stage enables, back to front
	assign en_out = !out_valid || out_ready;
	assign en3 = !v_s3 || en_out;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cm_per_tick_q <= RST_CM_PER_TICK;
			max_flight_q <= RST_MAX_FLIGHT;
			filt_cfg_q.min_distance_q8 <= RST_MIN_DISTANCE;
			filt_cfg_q.max_distance_q8 <= RST_MAX_DISTANCE;
			filt_cfg_q.outlier_threshold_q8 <= RST_OUTLIER;
			filt_cfg_q.smoothing_shift <= RST_SMOOTH_SHIFT;
			filt_cfg_q.fresh_min_count <= RST_FRESH_MIN;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CM_PER_TICK: begin
					cm_per_tick_q <= cfg_data[15:0];
				end
				REG_MAX_FLIGHT: begin
					max_flight_q <= cfg_data[19:0];
				end
				REG_MIN_DISTANCE: begin
					filt_cfg_q.min_distance_q8 <= cfg_data[23:0];
				end
				REG_MAX_DISTANCE: begin
					filt_cfg_q.max_distance_q8 <= cfg_data[23:0];
				end
				REG_OUTLIER: begin
					filt_cfg_q.outlier_threshold_q8 <= cfg_data[23:0];
				end
				REG_SMOOTH_SHIFT: begin
					filt_cfg_q.smoothing_shift <= cfg_data[2:0];
				end
				REG_FRESH_MIN: begin
					filt_cfg_q.fresh_min_count <= cfg_data[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Flight stage logic
	trf_flight u_flight (
		.poll_tx_time     (item_s1.poll_tx_time),
		.resp_rx_time     (item_s1.resp_rx_time),
		.reply_delay      (item_s1.reply_delay),
		.max_flight_ticks (max_flight_q),
		.tof              (tof),
		.flight_ok        (flight_ok)
	);

	// Scale stage logic
	trf_scale u_scale (
		.tof             (flight_s2.tof),
		.cm_per_tick_q16 (cm_per_tick_q),
		.raw             (raw)
	);

	// Anchor state and result forming
	trf_anchor_bank #(
		.ANCHOR_COUNT (ANCHOR_COUNT)
	) u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (filt_cfg_q),
		.sample (sample_s3),
		.update (v_s3 && en_out),
		.result (result)
	);

	// Advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en_out) begin
				out_valid <= v_s3;
			end
		end
	end

	// Advance stage payloads
	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			item_s1 <= in_item;
		end
		if (en2 && v_s1) begin
			flight_s2.opcode <= item_s1.opcode;
			flight_s2.anchor <= item_s1.anchor_index;
			flight_s2.flight_ok <= flight_ok;
			flight_s2.tof <= tof;
		end
		if (en3 && v_s2) begin
			sample_s3.opcode <= flight_s2.opcode;
			sample_s3.anchor <= flight_s2.anchor;
			sample_s3.flight_ok <= flight_s2.flight_ok;
			sample_s3.raw <= raw;
		end
		if (en_out && v_s3) begin
			out_item <= result;
		end
	end

endmodule

>>> sim/twr_range_filter_top_test.sv
// Self-checking bench for twr_range_filter_top: directed and random requests.
// Holds its own per-anchor ranging filter predictor and checks every result.
// Depends on trf_pkg and the RTL of twr_range_filter_top.
module twr_range_filter_top_test;
	import trf_pkg::*;

	localparam int ANCHOR_COUNT = 6;
	localparam int SEGMENTS = 6;
	localparam int ITEMS_PER_SEGMENT = 256;
	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 8;
	// Index with no register behind it: writes there must be ignored
	localparam logic [2:0] REG_SPARE = 3'd7;

	typedef struct {
		in_t  req;
		bit   typed;
		out_t result;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_item;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Expected result typed into the table, carried along with the request
	bit drv_typed = 1'b0;
	out_t drv_typed_result = '0;

	// Shadow registers
	logic [15:0] cm_per_tick;
	logic [19:0] max_flight;
	logic [23:0] min_dist;
	logic [23:0] max_dist;
	logic [23:0] outlier_jump;
	logic [2:0]  shift;
	logic [7:0]  fresh_min;

	// Shadow anchor state
	logic [23:0] est_q8 [ANCHOR_COUNT];
	bit          seeded [ANCHOR_COUNT];
	logic [7:0]  sample_count [ANCHOR_COUNT];
	bit          fresh [ANCHOR_COUNT];

	out_t pending_results [$];
	stim_row_t directed_rows [$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatch_count = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int settings_used = 1;
	int status_hits [8];
	int quiet_cycles = 0;
	out_t wanted;
	out_t predicted;

	twr_range_filter_top #(
		.ANCHOR_COUNT(ANCHOR_COUNT)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	// Filtered estimate in millimeters, zero until the anchor is seeded
	function automatic logic [15:0] estimate_in_mm(int a);
		logic [63:0] mm;
		if (!seeded[a]) return '0;
		mm = ({40'd0, est_q8[a]} * 64'd10) >> 8;
		return (mm > {48'd0, MM_MAX}) ? MM_MAX : mm[15:0];
	endfunction

	// Work out the result of one request and advance the anchor state
	function automatic out_t next_filter_result(in_t req);
		out_t r;
		longint span;
		longint flight;
		logic [63:0] scaled;
		logic [63:0] gap;
		logic [63:0] blend;
		logic [23:0] raw;
		logic [15:0] mask;
		int a;
		r = '0;
		if (req.opcode == OP_SLOT_END) begin
			mask = '0;
			for (a = 0; a < ANCHOR_COUNT; a++) begin
				if (fresh[a] && sample_count[a] >= fresh_min)
					mask[a] = 1'b1;
				fresh[a] = 1'b0;
			end
			r.status = ST_MASK;
			r.slot_mask = mask;
			return r;
		end
		r.anchor_out = req.anchor_index;
		if (req.anchor_index >= ANCHOR_COUNT) begin
			r.status = ST_BAD_INDEX;
			return r;
		end
		a = req.anchor_index;
		// Signed round trip minus reply, halved toward zero
		span = longint'({24'd0, req.resp_rx_time}) - longint'({24'd0, req.poll_tx_time})
			- longint'({32'd0, req.reply_delay});
		flight = span / 2;
		if (flight < 0 || flight > longint'({44'd0, max_flight})) begin
			r.status = ST_BAD_FLIGHT;
			r.estimate_mm = estimate_in_mm(a);
			r.count_out = sample_count[a];
			return r;
		end
		scaled = (64'(flight) * {48'd0, cm_per_tick}) >> 8;
		raw = (scaled > {40'd0, RAW_MAX}) ? RAW_MAX : scaled[23:0];
		fresh[a] = 1'b1;
		if (raw < min_dist || raw > max_dist) begin
			r.status = ST_LIMITS;
		end else if (!seeded[a]) begin
			est_q8[a] = raw;
			seeded[a] = 1'b1;
			sample_count[a] = 8'd1;
			r.status = ST_SEEDED;
		end else begin
			gap = (raw >= est_q8[a]) ? {40'd0, raw - est_q8[a]} : {40'd0, est_q8[a] - raw};
			if (gap > {40'd0, outlier_jump}) begin
				r.status = ST_OUTLIER;
			end else begin
				blend = ({40'd0, raw} + ((64'd1 << shift) - 64'd1) * {40'd0, est_q8[a]}) >> shift;
				est_q8[a] = blend[23:0];
				if (sample_count[a] != COUNT_MAX)
					sample_count[a] = sample_count[a] + 8'd1;
				r.status = ST_AVERAGED;
			end
		end
		r.raw_distance_q8 = raw;
		r.estimate_mm = estimate_in_mm(a);
		r.count_out = sample_count[a];
		return r;
	endfunction

	// Build one random request, mostly well-formed range samples
	function automatic in_t make_request();
		in_t q;
		logic [127:0] noise;
		logic [39:0] poll;
		logic [31:0] reply;
		logic [63:0] resp;
		longint flight;
		longint diff;
		int kind;
		int pick;
		int a;
		noise = {$urandom, $urandom, $urandom, $urandom};
		q = noise[$bits(in_t)-1:0];
		kind = $urandom_range(99);
		if (kind < 8) begin
			q.opcode = OP_SLOT_END;
			return q;
		end
		if (kind < 16)
			return q;
		pick = $urandom_range(99);
		if (pick < 40)
			a = 0;
		else if (pick < 88)
			a = $urandom_range(ANCHOR_COUNT - 1);
		else
			a = $urandom_range(15, ANCHOR_COUNT);
		pick = $urandom_range(99);
		if (pick < 55 && a < ANCHOR_COUNT && seeded[a] && cm_per_tick != 0)
			flight = longint'({40'd0, est_q8[a]}) * 256 / longint'({48'd0, cm_per_tick})
				+ longint'($urandom_range(16)) - 8;
		else if (pick < 80)
			flight = longint'($urandom_range(32'(max_flight)));
		else if (pick < 88)
			flight = longint'({44'd0, max_flight}) + longint'($urandom_range(3, 1));
		else if (pick < 96)
			flight = 0 - longint'($urandom_range(1000, 1));
		else
			flight = longint'($urandom_range(32'h10_0000));
		reply = ($urandom_range(3) == 0) ? 32'($urandom_range(255)) : 32'($urandom);
		// Keep the poll time low enough that the response does not wrap
		poll = {8'($urandom_range(251)), 32'($urandom)};
		diff = longint'({32'd0, reply}) + 2 * flight + longint'($urandom_range(1));
		resp = {24'd0, poll} + 64'(diff);
		q.opcode = OP_RANGE;
		q.anchor_index = 4'(a);
		q.poll_tx_time = poll;
		q.resp_rx_time = resp[39:0];
		q.reply_delay = reply;
		return q;
	endfunction

	function automatic void add_row(logic op, logic [3:0] a, logic [39:0] poll,
		logic [39:0] resp, logic [31:0] reply, bit typed, status_t st,
		logic [23:0] raw, logic [15:0] mm, logic [7:0] cnt, logic [15:0] mask);
		stim_row_t row;
		row.req = '{opcode: op, anchor_index: a, poll_tx_time: poll,
			resp_rx_time: resp, reply_delay: reply};
		row.typed = typed;
		row.result = '{status: st, anchor_out: (op == OP_SLOT_END) ? 4'd0 : a,
			raw_distance_q8: raw, estimate_mm: mm, count_out: cnt, slot_mask: mask};
		directed_rows.push_back(row);
	endfunction

	task automatic report_field(string field, logic [23:0] want, logic [23:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatch_count++;
		end
	endtask

	// Present one request and hold it until taken
	task automatic send_request(in_t req, bit typed, out_t typed_result);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_item <= req;
		drv_typed <= typed;
		drv_typed_result <= typed_result;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		requests_sent++;
	endtask

	// Hold off new requests until every expected result has come back
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_register(logic [2:0] idx, logic [23:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_CM_PER_TICK:  cm_per_tick = data[15:0];
			REG_MAX_FLIGHT:   max_flight = data[19:0];
			REG_MIN_DISTANCE: min_dist = data;
			REG_MAX_DISTANCE: max_dist = data;
			REG_OUTLIER:      outlier_jump = data;
			REG_SMOOTH_SHIFT: shift = data[2:0];
			REG_FRESH_MIN:    fresh_min = data[7:0];
			default: ;
		endcase
	endtask

	// Load the register set of one segment; junk goes into unused upper bits
	task automatic apply_setting(int seg);
		logic [23:0] lo;
		case (seg)
			1: begin
				write_register(REG_CM_PER_TICK, {8'($urandom), 16'd30748});
				write_register(REG_MAX_FLIGHT, {4'($urandom), 20'd40000});
				write_register(REG_MIN_DISTANCE, 24'd2560);
				write_register(REG_MAX_DISTANCE, 24'd256000);
				write_register(REG_OUTLIER, 24'd5120);
				write_register(REG_SMOOTH_SHIFT, {21'($urandom), 3'd3});
				write_register(REG_FRESH_MIN, {16'($urandom), 8'd1});
			end
			2: begin
				write_register(REG_CM_PER_TICK, 24'h00FFFF);
				write_register(REG_MAX_FLIGHT, 24'h0FFFFF);
				write_register(REG_MIN_DISTANCE, 24'd0);
				write_register(REG_MAX_DISTANCE, RAW_MAX);
				write_register(REG_OUTLIER, RAW_MAX);
				write_register(REG_SMOOTH_SHIFT, 24'd0);
				write_register(REG_FRESH_MIN, 24'd0);
			end
			3: begin
				write_register(REG_CM_PER_TICK, {8'hFF, 16'd0});
				write_register(REG_MAX_FLIGHT, {4'hF, 20'd0});
				write_register(REG_MIN_DISTANCE, 24'd0);
				write_register(REG_MAX_DISTANCE, 24'd0);
				write_register(REG_OUTLIER, 24'd0);
				write_register(REG_SMOOTH_SHIFT, 24'd7);
				write_register(REG_FRESH_MIN, 24'd255);
			end
			4: begin
				lo = 24'($urandom_range(50000));
				write_register(REG_CM_PER_TICK, 24'($urandom_range(65535, 20000)));
				write_register(REG_MAX_FLIGHT, 24'($urandom_range(32'hF_FFFF, 1000)));
				write_register(REG_MIN_DISTANCE, lo);
				write_register(REG_MAX_DISTANCE, lo + 24'($urandom_range(32'h7F_FFFF)));
				write_register(REG_OUTLIER, 24'($urandom));
				write_register(REG_SMOOTH_SHIFT, 24'($urandom_range(7)));
				write_register(REG_FRESH_MIN, 24'($urandom_range(10, 1)));
			end
			default: begin
				write_register(REG_CM_PER_TICK, 24'd40000);
				write_register(REG_MAX_FLIGHT, 24'd300000);
				write_register(REG_MIN_DISTANCE, 24'd1000);
				write_register(REG_MAX_DISTANCE, 24'd3000000);
				write_register(REG_OUTLIER, 24'd50000);
				write_register(REG_SMOOTH_SHIFT, 24'd2);
				write_register(REG_FRESH_MIN, 24'd2);
			end
		endcase
		write_register(REG_SPARE, 24'($urandom));
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Predict each accepted request; a typed table entry takes precedence
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			predicted = next_filter_result(in_item);
			pending_results.push_back(drv_typed ? drv_typed_result : predicted);
		end
	end

	// Check each accepted result against the oldest expectation; stall at random
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: status %0d anchor %0d",
					out_item.status, out_item.anchor_out);
				mismatch_count++;
			end else begin
				wanted = pending_results.pop_front();
				report_field("status", 24'(wanted.status), 24'(out_item.status));
				report_field("anchor_out", 24'(wanted.anchor_out), 24'(out_item.anchor_out));
				report_field("raw_distance_q8", wanted.raw_distance_q8,
					out_item.raw_distance_q8);
				report_field("estimate_mm", 24'(wanted.estimate_mm), 24'(out_item.estimate_mm));
				report_field("count_out", 24'(wanted.count_out), 24'(out_item.count_out));
				report_field("slot_mask", 24'(wanted.slot_mask), 24'(out_item.slot_mask));
				status_hits[wanted.status]++;
				results_checked++;
			end
		end
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Drop the run when neither channel moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("no handshake for %0d cycles", QUIET_LIMIT);
				$display("twr_range_filter_top_test: FAIL");
				$finish;
			end
		end
	end

	initial begin
		int seg;
		int n;
		int i;
		cm_per_tick = RST_CM_PER_TICK;
		max_flight = RST_MAX_FLIGHT;
		min_dist = RST_MIN_DISTANCE;
		max_dist = RST_MAX_DISTANCE;
		outlier_jump = RST_OUTLIER;
		shift = RST_SMOOTH_SHIFT;
		fresh_min = RST_FRESH_MIN;
		for (i = 0; i < ANCHOR_COUNT; i++) begin
			est_q8[i] = '0;
			seeded[i] = 1'b0;
			sample_count[i] = '0;
			fresh[i] = 1'b0;
		end
		for (i = 0; i < 8; i++)
			status_hits[i] = 0;

		// Directed table at the reset register values
		add_row(OP_SLOT_END, 4'd0, '0, '0, '0, 1, ST_MASK, '0, '0, '0, '0);
		add_row(OP_RANGE, 4'd15, '1, '1, '1, 1, ST_BAD_INDEX, '0, '0, '0, '0);
		add_row(OP_RANGE, 4'd6, '0, 40'd100, '0, 1, ST_BAD_INDEX, '0, '0, '0, '0);
		// Response before poll: negative flight
		add_row(OP_RANGE, 4'd0, '1, '0, '0, 1, ST_BAD_FLIGHT, '0, '0, '0, '0);
		// One tick past the flight limit
		add_row(OP_RANGE, 4'd1, '0, 40'd80002, '0, 1, ST_BAD_FLIGHT, '0, '0, '0, '0);
		add_row(OP_RANGE, 4'd0, '0, '1, '1, 1, ST_BAD_FLIGHT, '0, '0, '0, '0);
		// Reply longer than the round trip by three: halves to minus one
		add_row(OP_RANGE, 4'd0, '0, 40'd10, 32'd13, 1, ST_BAD_FLIGHT, '0, '0, '0, '0);
		// Zero flight seeds at zero distance
		add_row(OP_RANGE, 4'd2, 40'd1000, 40'd1000, '0, 1, ST_SEEDED, '0, '0, 8'd1, '0);
		// Flight exactly at the limit lands beyond the distance window
		add_row(OP_RANGE, 4'd3, '0, 40'd85000, 32'd5000, 1, ST_LIMITS, 24'd4804375,
			'0, '0, '0);
		// Minus one halves toward zero, so it is a good zero flight
		add_row(OP_RANGE, 4'd4, 40'd1, '0, '0, 1, ST_SEEDED, '0, '0, 8'd1, '0);
		add_row(OP_RANGE, 4'd5, '0, 40'd3, '0, 0, ST_AVERAGED, '0, '0, '0, '0);
		add_row(OP_RANGE, 4'd2, '0, 40'd207, 32'd7, 0, ST_AVERAGED, '0, '0, '0, '0);
		add_row(OP_RANGE, 4'd2, 40'd10, 40'd4010, '0, 0, ST_AVERAGED, '0, '0, '0, '0);
		add_row(OP_RANGE, 4'd5, '0, 40'd4, '0, 0, ST_AVERAGED, '0, '0, '0, '0);
		add_row(OP_RANGE, 4'd1, '0, 40'd50000, '0, 0, ST_AVERAGED, '0, '0, '0, '0);
		add_row(OP_SLOT_END, 4'd0, '0, '0, '0, 0, ST_MASK, '0, '0, '0, '0);
		// Second slot end right after: every fresh bit was cleared
		add_row(OP_SLOT_END, 4'd9, '1, '1, '1, 1, ST_MASK, '0, '0, '0, '0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (seg = 0; seg < SEGMENTS; seg++) begin
			// Sender-light, then receiver-light, then no idling at all
			case (seg / 2)
				0: begin
					send_idle_pct = 34;
					recv_idle_pct <= 60;
				end
				1: begin
					send_idle_pct = 60;
					recv_idle_pct <= 34;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct <= 0;
				end
			endcase
			if (seg > 0)
				apply_setting(seg);
			if (seg == 0) begin
				foreach (directed_rows[r])
					send_request(directed_rows[r].req, directed_rows[r].typed,
						directed_rows[r].result);
			end
			for (n = 0; n < ITEMS_PER_SEGMENT; n++) begin
				if (n == ITEMS_PER_SEGMENT / 2)
					wait_for_results();
				send_request(make_request(), 1'b0, '0);
			end
			wait_for_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			mismatch_count++;
		end
		$display("%0d requests sent, %0d results checked under %0d register sets",
			requests_sent, results_checked, settings_used);
		$display("averaged %0d seeded %0d limits %0d outlier %0d flight %0d index %0d mask %0d",
			status_hits[ST_AVERAGED], status_hits[ST_SEEDED], status_hits[ST_LIMITS],
			status_hits[ST_OUTLIER], status_hits[ST_BAD_FLIGHT], status_hits[ST_BAD_INDEX],
			status_hits[ST_MASK]);
		if (mismatch_count == 0)
			$display("twr_range_filter_top_test: PASS");
		else
			$display("twr_range_filter_top_test: FAIL");
		$finish;
	end

endmodule
